FILE: rtl/bss_pkg.sv
// Shared types and constants for the bounded set store.
`default_nettype none

package bss_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int ELEM_BITS_DEF = 16;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        command;
    logic [15:0] element;
  } req_t;

  typedef struct packed {
    logic       was_member;
    logic [4:0] count;
    logic       is_full;
    logic       is_empty;
    logic       overflow;
  } rsp_t;

  // Per-transaction update controls broadcast to every cell.
  typedef struct packed {
    logic insert_en;
    logic delete_en;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/bss_cell.sv
// One slot of the set: holds a value, compares it and shifts it down on delete.
`default_nettype none

module bss_cell
  import bss_pkg::*;
#(
  parameter int IDX       = 0,
  parameter int CNT_W     = 5,
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire cell_ctl_t            ctl,
  input  wire logic [CNT_W-1:0]     fill,
  input  wire logic [ELEM_BITS-1:0] element,
  input  wire logic                 hit_in,
  input  wire logic [ELEM_BITS-1:0] upper_value,
  output logic                      hit_out,
  output logic                      match,
  output logic [ELEM_BITS-1:0]      value
);

  logic occupied;
  logic tail;

  assign occupied = CNT_W'(IDX) < fill;
  assign tail     = CNT_W'(IDX) == fill;
  assign match    = occupied && (value == element);
  // Set once the deleted entry is at or below this slot.
  assign hit_out  = hit_in | match;

  always_ff @(posedge clk) begin
    if (ctl.delete_en && hit_out && occupied) begin
      value <= upper_value;
    end else if (ctl.insert_en && tail) begin
      value <= element;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bounded_set_store_unit.sv
// Top level of the bounded set store: cell chain, fill count and response register.
//
//   channel | direction | payload | transaction when
//   req     | in        | req_t   | req_valid  && req_ready
//   rsp     | out       | rsp_t   | rsp_valid  && rsp_ready
//
// All cells compare in parallel, and the delete shift moves every later entry
// one cell down in the same edge that loads the response register.
// A request is taken whenever the response register is empty or being drained,
// so one transaction per cycle is sustained; a stalled rsp holds req off.
// Reset clears the fill count and the response valid; slot contents are left as is.
`default_nettype none

module bounded_set_store_unit
  import bss_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]     fill_count;
  logic [CNT_W-1:0]     fill_count_next;
  logic [ELEM_BITS-1:0] elem;
  logic [ELEM_BITS+15:0] elem_ext;
  logic [CNT_W+4:0]     count_ext;
  logic                 fire;
  logic                 member;
  logic                 full_now;
  logic                 overflow_now;
  cell_ctl_t            ctl;
  rsp_t                 rsp_next;

  logic [ELEM_BITS-1:0] cell_value [CAPACITY];
  logic [ELEM_BITS-1:0] cell_upper [CAPACITY];
  logic [CAPACITY:0]    hit_chain;
  logic [CAPACITY-1:0]  cell_match;

  assign req_ready = !rsp_valid || rsp_ready;
  assign fire      = req_valid && req_ready;

  assign elem_ext = {{ELEM_BITS{1'b0}}, req.element};
  assign elem     = elem_ext[ELEM_BITS-1:0];

  assign member   = |cell_match;
  assign full_now = fill_count == CNT_W'(CAPACITY);

  always_comb begin
    ctl             = '0;
    overflow_now    = 1'b0;
    fill_count_next = fill_count;
    unique case (req.command)
      CMD_INSERT: begin
        if (!member) begin
          if (full_now) begin
            overflow_now = 1'b1;
          end else begin
            ctl.insert_en   = fire;
            fill_count_next = fill_count + 1'b1;
          end
        end
      end
      CMD_DELETE: begin
        if (member) begin
          ctl.delete_en   = fire;
          fill_count_next = fill_count - 1'b1;
        end
      end
      CMD_QUERY: begin
      end
      CMD_CLEAR: begin
        fill_count_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_last
      assign cell_upper[i] = cell_value[i];
    end else begin : g_mid
      assign cell_upper[i] = cell_value[i+1];
    end

    bss_cell #(
      .IDX       (i),
      .CNT_W     (CNT_W),
      .ELEM_BITS (ELEM_BITS)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .fill        (fill_count),
      .element     (elem),
      .hit_in      (hit_chain[i]),
      .upper_value (cell_upper[i]),
      .hit_out     (hit_chain[i+1]),
      .match       (cell_match[i]),
      .value       (cell_value[i])
    );
  end

  assign count_ext = {5'b0, fill_count_next};

  always_comb begin
    rsp_next.was_member = member;
    rsp_next.count      = count_ext[4:0];
    rsp_next.is_full    = fill_count_next == CNT_W'(CAPACITY);
    rsp_next.is_empty   = fill_count_next == '0;
    rsp_next.overflow   = overflow_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (fire) begin
        fill_count <= fill_count_next;
        rsp_valid  <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.overflow |-> rsp.is_full && !rsp.was_member)
    else $error("overflow reported on a set that is not full");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    fire && req.command == CMD_CLEAR |=> fill_count == '0 && rsp.is_empty)
    else $error("clear left entries behind");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(fill_count))
    else $error("fill count changed without a transaction");

endmodule

`default_nettype wire

FILE: tb/bounded_set_store_checker.sv
// Checker for the bounded set store: mirrors the set, predicts each response and compares.
`default_nettype none

module bounded_set_store_checker
  import bss_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  input  wire logic req_ready,
  input  wire req_t req,
  input  wire logic rsp_valid,
  input  wire logic rsp_ready,
  input  wire rsp_t rsp,
  output int        mismatches,
  output int        pending
);

  localparam int CAP = CAPACITY_DEF;

  logic [15:0] set_slots [CAP];
  int          set_fill;
  rsp_t        expected_rsp_q [$];

  initial begin
    mismatches = 0;
    pending    = 0;
    set_fill   = 0;
  end

  function automatic rsp_t apply_request(req_t r);
    rsp_t res;
    int   pos;
    logic hit;
    pos = CAP;
    hit = 1'b0;
    for (int i = 0; i < set_fill; i++) begin
      if (!hit && set_slots[i] == r.element) begin
        hit = 1'b1;
        pos = i;
      end
    end
    res = '0;
    case (r.command)
      CMD_INSERT: begin
        if (!hit) begin
          if (set_fill >= CAP) begin
            res.overflow = 1'b1;
          end else begin
            set_slots[set_fill] = r.element;
            set_fill++;
          end
        end
      end
      CMD_DELETE: begin
        if (hit) begin
          for (int i = pos; i < set_fill - 1; i++) set_slots[i] = set_slots[i + 1];
          set_fill--;
        end
      end
      CMD_CLEAR: begin
        set_fill = 0;
      end
      default: ;
    endcase
    res.was_member = hit;
    res.count      = 5'(set_fill);
    res.is_full    = (set_fill == CAP);
    res.is_empty   = (set_fill == 0);
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    rsp_t exp_r;
    if (rst) begin
      set_fill = 0;
      expected_rsp_q.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp_q.size() == 0) begin
          $error("rsp transaction with no request outstanding");
          mismatches++;
        end else begin
          exp_r = expected_rsp_q.pop_front();
          check_field("was_member", exp_r.was_member, rsp.was_member);
          check_field("count", exp_r.count, rsp.count);
          check_field("is_full", exp_r.is_full, rsp.is_full);
          check_field("is_empty", exp_r.is_empty, rsp.is_empty);
          check_field("overflow", exp_r.overflow, rsp.overflow);
        end
      end
      if (req_valid && req_ready) expected_rsp_q.push_back(apply_request(req));
    end
    pending <= expected_rsp_q.size();
  end

endmodule

`default_nettype wire

FILE: tb/bounded_set_store_unit_tb.sv
// Testbench top for the bounded set store: clock, reset, request stimulus and verdict.
`default_nettype none

module bounded_set_store_unit_tb;
  import bss_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 80;
  localparam int QUIET_LO     = 300;
  localparam int QUIET_HI     = 450;
  localparam int HOLD_AT      = 520;
  localparam int DRAIN_AT     = 650;
  localparam int POOL_SIZE    = 24;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_ready = 1'b0;
  req_t req       = '0;
  logic req_ready;
  logic rsp_valid;
  rsp_t rsp;
  int   mismatches;
  int   pending;
  int   sent        = 0;
  int   hold_left   = 0;
  bit   hold_done   = 1'b0;
  int   idle_cycles = 0;
  logic [15:0] pool [POOL_SIZE];

  always #5 clk = ~clk;

  bounded_set_store_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  bounded_set_store_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .mismatches (mismatches),
    .pending    (pending)
  );

  function automatic bit quiet_window();
    return sent >= QUIET_LO && sent < QUIET_HI;
  endfunction

  // response side: random stalls, one long hold-off, one stall-free window
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && sent >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else if (quiet_window()) begin
      rsp_ready <= 1'b1;
    end else begin
      rsp_ready <= ($urandom_range(99) >= 23);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_request(cmd_t c, logic [15:0] e);
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= '{command: c, element: e};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sent++;
  endtask

  task automatic sender_gaps();
    while (!quiet_window() && $urandom_range(99) < 23) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
  endtask

  task automatic drain_responses();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int   pick;
    cmd_t c;
    logic [15:0] e;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty-set corners, fill to capacity, overflow, deletes at first, middle and last position
    send_request(CMD_CLEAR, 16'h0000);
    send_request(CMD_QUERY, 16'h0000);
    send_request(CMD_DELETE, 16'hFFFF);
    send_request(CMD_INSERT, 16'h0000);
    send_request(CMD_INSERT, 16'hFFFF);
    send_request(CMD_INSERT, 16'hFFFF);
    for (int i = 0; i < 14; i++) send_request(CMD_INSERT, 16'h0001 << i);
    send_request(CMD_INSERT, 16'h8000);
    send_request(CMD_INSERT, 16'h0004);
    send_request(CMD_QUERY, 16'hFFFF);
    send_request(CMD_DELETE, 16'h0020);
    send_request(CMD_DELETE, 16'h0000);
    send_request(CMD_DELETE, 16'h2000);
    send_request(CMD_DELETE, 16'h5555);
    send_request(CMD_CLEAR, 16'hFFFF);
    send_request(CMD_QUERY, 16'hFFFF);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        for (int k = 0; k < POOL_SIZE; k++) pool[k] = 16'($urandom);
      end
      pick = $urandom_range(199);
      if (pick < 90) c = CMD_INSERT;
      else if (pick < 145) c = CMD_DELETE;
      else if (pick < 197) c = CMD_QUERY;
      else c = CMD_CLEAR;
      if ($urandom_range(99) < 85) e = pool[$urandom_range(POOL_SIZE - 1)];
      else e = 16'($urandom);
      sender_gaps();
      send_request(c, e);
      if (sent == DRAIN_AT) drain_responses();
    end

    drain_responses();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
